### design/tsas_pkg.sv
// Package for the thread slot allocator and scheduler.
// Holds slot state, operation, status and register codes and the
// controller-datapath interface types. No dependencies.
package tsas_pkg;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;
  localparam logic [1:0] ST_RUNNING = 2'd3;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_YIELD  = 2'd1;
  localparam logic [1:0] OP_EXIT   = 2'd2;
  localparam logic [1:0] OP_IDLE   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_NO_RUN  = 2'd2;

  localparam logic REG_STACK_TOP    = 1'b0;
  localparam logic REG_STACK_STRIDE = 1'b1;

  localparam logic [31:0] STACK_TOP_RESET    = 32'h00EF_FFF0;
  localparam logic [15:0] STACK_STRIDE_RESET = 16'd1000;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
    logic read;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic out_free;
  } dp_stat_t;

  function automatic logic slot_match(logic [1:0] op, logic [1:0] st);
    logic m;
    if (op == OP_CREATE) begin
      m = (st == ST_FREE);
    end else begin
      m = (st == ST_READY) || (st == ST_WAITING);
    end
    return m;
  endfunction

endpackage

### design/tsas_ctrl.sv
// Controller state machine of the thread slot scheduler.
// Sequences accept, slot scan, commit, entry read and result transfer.
// Depends on tsas_pkg.
module tsas_ctrl
  import tsas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] func,
  input  dp_stat_t   stat,
  output logic       in_ready,
  output ctl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = (func == OP_IDLE) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit || stat.last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/tsas_datapath.sv
// Datapath of the thread slot scheduler: slot state table, entry memory,
// scan pointer, stack base multiply and output register.
// Depends on tsas_pkg.
module tsas_datapath
  import tsas_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  func,
  input  logic [31:0] entry_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  thread_id,
  output logic [31:0] stack_base,
  output logic [31:0] current_pc
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int PW = SW + 16;
  localparam logic [SW-1:0] IDLE_SLOT = SW'(NUM_SLOTS - 1);

  logic [31:0]   stack_top;
  logic [15:0]   stack_stride;
  logic [1:0]    slot_state [NUM_SLOTS];
  logic [31:0]   slot_entry [NUM_SLOTS];
  logic [SW-1:0] current_slot;

  logic [1:0]    op;
  logic [31:0]   entry;
  logic [SW-1:0] idx;
  logic [CW-1:0] remain;
  logic          found;
  logic [SW-1:0] shown;
  logic [1:0]    result_status;
  logic [31:0]   entry_rd;
  logic [PW-1:0] product;
  logic          hit;
  logic [SW-1:0] cur_succ;
  logic [SW-1:0] idx_succ;
  logic [SW+4:0] shown_ext;

  assign hit      = slot_match(op, slot_state[idx]);
  assign cur_succ = (current_slot == IDLE_SLOT) ? '0 : current_slot + 1'b1;
  assign idx_succ = (idx == IDLE_SLOT) ? '0 : idx + 1'b1;

  assign stat.hit      = hit;
  assign stat.last     = (remain == CW'(1));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top    <= STACK_TOP_RESET;
      stack_stride <= STACK_STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STACK_TOP:    stack_top    <= cfg_data;
        REG_STACK_STRIDE: stack_stride <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= func;
      entry  <= entry_address;
      idx    <= (func == OP_CREATE) ? '0 : cur_succ;
      remain <= (func == OP_CREATE) ? CW'(NUM_SLOTS) : CW'(NUM_SLOTS - 1);
      found  <= 1'b0;
    end else if (cmd.scan_step) begin
      found <= hit;
      if (!hit) begin
        idx    <= idx_succ;
        remain <= remain - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_slot <= IDLE_SLOT;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_state[i] <= ST_FREE;
      end
    end else if (cmd.commit) begin
      if (op == OP_IDLE) begin
        slot_state[IDLE_SLOT] <= ST_RUNNING;
        current_slot          <= IDLE_SLOT;
      end else if (found) begin
        if (op == OP_CREATE) begin
          slot_state[idx] <= ST_READY;
        end else begin
          slot_state[current_slot] <= (op == OP_YIELD) ? ST_WAITING : ST_FREE;
          slot_state[idx]          <= ST_RUNNING;
          current_slot             <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op == OP_IDLE) begin
        slot_entry[IDLE_SLOT] <= entry;
      end else if (found && op == OP_CREATE) begin
        slot_entry[idx] <= entry;
      end
    end
    if (cmd.read) begin
      entry_rd <= slot_entry[current_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (op)
        OP_CREATE: begin
          shown         <= found ? idx : current_slot;
          result_status <= found ? STAT_OK : STAT_NO_FREE;
        end
        OP_YIELD, OP_EXIT: begin
          shown         <= found ? idx : current_slot;
          result_status <= found ? STAT_OK : STAT_NO_RUN;
        end
        default: begin
          shown         <= IDLE_SLOT;
          result_status <= STAT_OK;
        end
      endcase
    end
    if (cmd.read) begin
      product <= PW'(shown) * PW'(stack_stride);
    end
  end

  assign shown_ext = {5'b0, shown};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= result_status;
      thread_id  <= shown_ext[4:0];
      stack_base <= stack_top - 32'(product);
      current_pc <= entry_rd;
    end
  end

endmodule

### design/thread_slot_allocator_scheduler_unit.sv
// Top level of the thread slot allocator and round-robin scheduler.
// Joins tsas_ctrl and tsas_datapath; depends on tsas_pkg.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    func, entry_address
//   out      source     out_valid / out_ready  status, thread_id, stack_base, current_pc
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// Create scans up to NUM_SLOTS slots, one slot a cycle; yield and exit scan up to
// NUM_SLOTS - 1 slots the same way; start idle skips the scan.
// The result register holds one result; the next item is taken while it waits,
// and its result is stalled in the controller until that register frees up.
// Synchronous reset frees all slots and makes the idle slot current.
module thread_slot_allocator_scheduler_unit
  import tsas_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] entry_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  thread_id,
  output logic [31:0] stack_base,
  output logic [31:0] current_pc,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  tsas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tsas_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (func),
    .entry_address (entry_address),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .thread_id     (thread_id),
    .stack_base    (stack_base),
    .current_pc    (current_pc)
  );

endmodule

### design/tsas_checker.sv
// Port-level checks for the thread slot scheduler, bound to its top level.
// Depends on tsas_pkg.
module tsas_checker
  import tsas_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [4:0]  thread_id,
  input logic [31:0] stack_base
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer accepted while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(thread_id)
      && $stable(stack_base))
    else $error("stalled result changed");

endmodule

bind thread_slot_allocator_scheduler_unit tsas_checker u_chk (.*);

### dv/slot_schedule_checker.sv
`timescale 1ns / 100ps
// Checker for the thread slot scheduler: watches the input, output and register
// ports, predicts each result from its own slot table and compares it field by field.
// Depends on tsas_pkg.
module slot_schedule_checker
  import tsas_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] entry_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [4:0]  thread_id,
  input  logic [31:0] stack_base,
  input  logic [31:0] current_pc,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int IDLE_SLOT = NUM_SLOTS - 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  thread_id;
    logic [31:0] stack_base;
    logic [31:0] current_pc;
  } sched_outcome_t;

  logic [1:0]     slot_st [NUM_SLOTS];
  logic [31:0]    slot_pc [NUM_SLOTS];
  int             cur_slot;
  logic [31:0]    stk_top;
  logic [15:0]    stk_stride;
  sched_outcome_t sched_outcomes[$];
  int             fails = 0;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic sched_outcome_t schedule_op(input logic [1:0] op, input logic [31:0] addr);
    sched_outcome_t r;
    int shown;
    int cand;
    r.status = STAT_OK;
    shown = cur_slot;
    if (op == OP_CREATE) begin
      r.status = STAT_NO_FREE;
      for (int i = 0; i < NUM_SLOTS && r.status != STAT_OK; i++) begin
        if (slot_st[i] == ST_FREE) begin
          slot_st[i] = ST_READY;
          slot_pc[i] = addr;
          shown = i;
          r.status = STAT_OK;
        end
      end
    end else if (op == OP_YIELD || op == OP_EXIT) begin
      r.status = STAT_NO_RUN;
      for (int k = 1; k < NUM_SLOTS && r.status != STAT_OK; k++) begin
        cand = (cur_slot + k) % NUM_SLOTS;
        if (slot_st[cand] == ST_READY || slot_st[cand] == ST_WAITING) begin
          slot_st[cur_slot] = (op == OP_YIELD) ? ST_WAITING : ST_FREE;
          slot_st[cand] = ST_RUNNING;
          cur_slot = cand;
          shown = cand;
          r.status = STAT_OK;
        end
      end
    end else begin
      slot_pc[IDLE_SLOT] = addr;
      slot_st[IDLE_SLOT] = ST_RUNNING;
      cur_slot = IDLE_SLOT;
      shown = IDLE_SLOT;
    end
    r.thread_id = 5'(shown);
    r.stack_base = stk_top - 32'(shown) * 32'(stk_stride);
    r.current_pc = slot_pc[cur_slot];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    sched_outcome_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_st[i] = ST_FREE;
        slot_pc[i] = '0;
      end
      cur_slot = IDLE_SLOT;
      stk_top = STACK_TOP_RESET;
      stk_stride = STACK_STRIDE_RESET;
      sched_outcomes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (sched_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d thread_id %0d",
                   $time, status, thread_id);
          fails++;
        end else begin
          want = sched_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("thread_id", 32'(want.thread_id), 32'(thread_id));
          check_field("stack_base", want.stack_base, stack_base);
          check_field("current_pc", want.current_pc, current_pc);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_STACK_TOP) begin
          stk_top = cfg_data;
        end else begin
          stk_stride = cfg_data[15:0];
        end
      end
      if (in_valid && in_ready) begin
        sched_outcomes.push_back(schedule_op(func, entry_address));
      end
    end
    mismatches <= fails;
    outstanding <= sched_outcomes.size();
  end

endmodule

### dv/thread_slot_allocator_scheduler_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the thread slot scheduler: drives directed and random
// operations and register settings, and gives the verdict.
// Depends on tsas_pkg, the scheduler RTL and slot_schedule_checker.
module thread_slot_allocator_scheduler_unit_test;
  import tsas_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 242;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = OP_CREATE;
  logic [31:0] entry_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [4:0]  thread_id;
  logic [31:0] stack_base;
  logic [31:0] current_pc;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_STACK_TOP;
  logic [31:0] cfg_data = '0;
  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  thread_slot_allocator_scheduler_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .entry_address(entry_address),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .thread_id(thread_id),
    .stack_base(stack_base), .current_pc(current_pc),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slot_schedule_checker u_sched_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .entry_address(entry_address),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .thread_id(thread_id),
    .stack_base(stack_base), .current_pc(current_pc),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [31:0] addr);
    in_valid <= 1'b1;
    func <= op;
    entry_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // drop valid and hold until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stack_regs(input logic [31:0] top_word, input logic [31:0] stride_word);
    cfg_we <= 1'b1;
    cfg_index <= REG_STACK_TOP;
    cfg_data <= top_word;
    @(posedge clk);
    cfg_index <= REG_STACK_STRIDE;
    cfg_data <= stride_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] pick_op(input int mode);
    int r;
    r = $urandom_range(99);
    if (r == 99) return OP_IDLE;
    case (mode)
      0:       return (r < 70) ? OP_CREATE : (r < 85) ? OP_YIELD : OP_EXIT;
      1:       return (r < 15) ? OP_CREATE : (r < 50) ? OP_YIELD : OP_EXIT;
      default: return (r < 35) ? OP_CREATE : (r < 65) ? OP_YIELD : OP_EXIT;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    int mode;
    mode = 2;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle slot first, so the current slot always has an entry
    send_op(OP_IDLE, 32'h0);
    send_op(OP_YIELD, $urandom);
    send_op(OP_EXIT, $urandom);
    send_op(OP_CREATE, 32'hFFFF_FFFF);
    send_op(OP_CREATE, 32'h0);
    send_op(OP_CREATE, $urandom);
    send_op(OP_YIELD, $urandom);
    send_op(OP_YIELD, $urandom);
    send_op(OP_EXIT, $urandom);
    send_op(OP_CREATE, $urandom);
    send_op(OP_IDLE, 32'hA5A5_5A5A);
    send_op(OP_EXIT, $urandom);
    send_op(OP_YIELD, $urandom);
    send_op(OP_EXIT, $urandom);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       write_stack_regs(STACK_TOP_RESET, 32'(STACK_STRIDE_RESET));
        1:       write_stack_regs(32'hFFFF_FFFF, 32'h0000_FFFF);
        2:       write_stack_regs(32'h0, 32'h0);
        3:       write_stack_regs(32'h0, 32'h0000_FFFF);
        4:       write_stack_regs($urandom, $urandom);
        5:       write_stack_regs(32'hFFFF_FFFF, 32'hFFFF_0000);
        6:       write_stack_regs($urandom, $urandom);
        default: write_stack_regs(STACK_TOP_RESET, 32'(STACK_STRIDE_RESET));
      endcase
      calm = (p == 2);
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) mode = $urandom_range(2);
        send_op(pick_op(mode), rand_entry());
      end
    end

    settle();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
